### hdl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, character codes and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int MagBits   = 64;
  localparam int DigitBits = 4;
  localparam int NumDigits = 20;                      // decimal digits of 2^64-1
  localparam int HexDigits = MagBits / DigitBits;
  localparam int DigRegBits = NumDigits * DigitBits;  // 80-bit digit register

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [3:0] RADIX_DEC  = 4'd10;
  localparam logic [3:0] DABBLE_MIN = 4'd5;
  localparam logic [3:0] DABBLE_ADD = 4'd3;

  // Digits of one number, most significant digit in the top nibble.
  typedef struct packed {
    logic [DigRegBits-1:0] digits;
    logic [4:0]            num_digits;
    logic [5:0]            field_width;
    logic                  pad_zero;
    logic                  negative;
  } conv_result_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < RADIX_DEC) begin
      digit_char = CHAR_ZERO + {4'd0, d};
    end else begin
      digit_char = CHAR_A + {4'd0, d - RADIX_DEC};
    end
  endfunction

endpackage

### hdl/i2a_conv.sv
// ----------------------------------------------------------------------------
// i2a_conv
// Bit-serial binary to BCD conversion (shift and add three) or hex nibble
// load, followed by a digit-serial strip of leading zero digits.
// ----------------------------------------------------------------------------
module i2a_conv
  import i2a_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                idle,
  input  logic [MagBits-1:0]  magnitude,
  input  logic                hex_base,
  input  logic [5:0]          field_width,
  input  logic                pad_zero,
  input  logic                negative,
  output logic                res_valid,
  input  logic                res_ready,
  output conv_result_t        res
);

  typedef enum logic [1:0] {IDLE, DABBLE, NORM, DONE} state_t;

  state_t                state;
  logic [MagBits-1:0]    bin;
  logic [5:0]            bit_cnt;
  logic [DigRegBits-1:0] bcd_adj;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (res.digits[i*DigitBits +: DigitBits] >= DABBLE_MIN) begin
        bcd_adj[i*DigitBits +: DigitBits] = res.digits[i*DigitBits +: DigitBits] + DABBLE_ADD;
      end else begin
        bcd_adj[i*DigitBits +: DigitBits] = res.digits[i*DigitBits +: DigitBits];
      end
    end
  end

  assign idle      = (state == IDLE);
  assign res_valid = (state == DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            res.field_width <= field_width;
            res.pad_zero    <= pad_zero;
            res.negative    <= negative;
            bit_cnt         <= '0;
            if (hex_base) begin
              res.digits     <= {magnitude, {(DigRegBits-MagBits){1'b0}}};
              res.num_digits <= 5'(HexDigits);
              state          <= NORM;
            end else begin
              res.digits     <= '0;
              bin            <= magnitude;
              res.num_digits <= 5'(NumDigits);
              state          <= DABBLE;
            end
          end
        end
        DABBLE: begin
          res.digits <= {bcd_adj[DigRegBits-2:0], bin[MagBits-1]};
          bin        <= {bin[MagBits-2:0], 1'b0};
          bit_cnt    <= bit_cnt + 6'd1;
          if (bit_cnt == 6'(MagBits-1)) begin
            state <= NORM;
          end
        end
        NORM: begin
          // Drop one leading zero digit a cycle; a zero value keeps one digit.
          if (res.digits[DigRegBits-1 -: DigitBits] == '0 && res.num_digits > 5'd1) begin
            res.digits     <= {res.digits[DigRegBits-DigitBits-1:0], {DigitBits{1'b0}}};
            res.num_digits <= res.num_digits - 5'd1;
          end else begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### hdl/i2a_emit.sv
// ----------------------------------------------------------------------------
// i2a_emit
// Character sequencer: sign, padding and digits, one character per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module i2a_emit
  import i2a_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         res_valid,
  output logic         res_ready,
  input  conv_result_t res,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);

  typedef enum logic [2:0] {IDLE, SIGN_PRE, PAD, SIGN_POST, DIGITS} state_t;

  state_t                state;
  state_t                state_next;
  logic [DigRegBits-1:0] digits;
  logic [4:0]            num_digits;
  logic [5:0]            pad_cnt;
  logic                  pad_zero;
  logic                  negative;
  logic [5:0]            len;
  logic [5:0]            pad_load;
  logic                  can_emit;
  logic [7:0]            char_next;
  logic                  last_next;

  assign res_ready = (state == IDLE);
  assign can_emit  = !m_tvalid || m_tready;

  assign len      = {1'b0, res.num_digits} + {5'd0, res.negative};
  assign pad_load = (res.field_width > len) ? res.field_width - len : '0;

  always_comb begin
    char_next  = digit_char(digits[DigRegBits-1 -: DigitBits]);
    last_next  = 1'b0;
    state_next = state;
    case (state)
      SIGN_PRE: begin
        char_next  = CHAR_MINUS;
        state_next = (pad_cnt != '0) ? PAD : DIGITS;
      end
      PAD: begin
        char_next = pad_zero ? CHAR_ZERO : CHAR_SPACE;
        if (pad_cnt == 6'd1) begin
          state_next = (negative && !pad_zero) ? SIGN_POST : DIGITS;
        end
      end
      SIGN_POST: begin
        char_next  = CHAR_MINUS;
        state_next = DIGITS;
      end
      DIGITS: begin
        last_next = (num_digits == 5'd1);
        if (num_digits == 5'd1) begin
          state_next = IDLE;
        end
      end
      default: state_next = state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == IDLE) begin
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (res_valid) begin
          digits     <= res.digits;
          num_digits <= res.num_digits;
          pad_cnt    <= pad_load;
          pad_zero   <= res.pad_zero;
          negative   <= res.negative;
          if (res.negative && res.pad_zero) begin
            state <= SIGN_PRE;
          end else if (pad_load != '0) begin
            state <= PAD;
          end else if (res.negative) begin
            state <= SIGN_POST;
          end else begin
            state <= DIGITS;
          end
        end
      end else if (can_emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= char_next;
        m_tlast  <= last_next;
        state    <= state_next;
        if (state == PAD) begin
          pad_cnt <= pad_cnt - 6'd1;
        end
        if (state == DIGITS) begin
          digits     <= {digits[DigRegBits-DigitBits-1:0], {DigitBits{1'b0}}};
          num_digits <= num_digits - 5'd1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### hdl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 64-bit magnitude as decimal or lowercase hex ASCII text.
// ----------------------------------------------------------------------------
// One word in gives one character word out per cycle while m_tready is high,
// most significant first, with tlast on the final character. A decimal number
// goes through the bit-serial BCD converter, then up to 19 leading zero digits
// are stripped; a hex number loads directly and strips up to 15 zeros. Emission
// gives max(field_width, digits + sign) characters, at most 63, once the
// sequencer has loaded the result. The converter works on the next number
// while the previous one is still being emitted.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // magnitude[63:0], field_width[69:64],
                                 // pad_zero[70], negative[71]
  input  logic        s_tuser,   // hex_base
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // ascii_char[7:0]
  output logic        m_tlast    // last_char
);

  logic         res_valid;
  logic         res_ready;
  conv_result_t res;

  i2a_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .start       (s_tvalid && s_tready),
    .idle        (s_tready),
    .magnitude   (s_tdata[63:0]),
    .hex_base    (s_tuser),
    .field_width (s_tdata[69:64]),
    .pad_zero    (s_tdata[70]),
    .negative    (s_tdata[71]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  i2a_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // A converted number waiting for the sequencer must not change.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("converter result changed while waiting");

  a_res_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.num_digits != 5'd0 && res.num_digits <= 5'(NumDigits))
    else $error("digit count out of range");

  // After stripping, the leading digit is nonzero unless the value is zero.
  a_res_norm: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.digits[DigRegBits-1 -: DigitBits] != '0 || res.num_digits == 5'd1)
    else $error("leading zero digit left in result");

endmodule
